>>> sv/mrpt_pkg.sv
package mrpt_pkg;

    localparam int unsigned CandWidth = 63;
    localparam int unsigned BaseCount = 7;
    localparam int unsigned BaseIdxW  = 3;

    // Fixed witness set, exact for every 63-bit value.
    function automatic logic [CandWidth-1:0] base_value(input logic [BaseIdxW-1:0] idx);
        logic [CandWidth-1:0] v;
        begin
            case (idx)
                3'd0:    v = 63'd2;
                3'd1:    v = 63'd325;
                3'd2:    v = 63'd9375;
                3'd3:    v = 63'd28178;
                3'd4:    v = 63'd450775;
                3'd5:    v = 63'd9780504;
                3'd6:    v = 63'd1795265022;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // Start and done handshake between the sequencer and the modular unit.
    typedef struct packed {
        logic start;
        logic done;
    } mul_ctrl_t;

endpackage

>>> sv/mrpt_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// acc = (acc*2 [+ x]) mod m, with x, acc < m < 2^63.
module mrpt_modmul #(
    parameter int unsigned Width = mrpt_pkg::CandWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [Width-1:0] op_x,
    input  logic [Width-1:0] op_y,
    input  logic [Width-1:0] modulus,
    output logic             done,
    output logic [Width-1:0] product
);

    localparam int unsigned CntW = $clog2(Width + 1);

    logic [Width-1:0] x_reg, y_reg, m_reg, acc_reg;
    logic [CntW-1:0]  cnt_reg;
    logic             busy_reg, done_reg;

    logic [Width:0] dbl, dbl_red, add, add_red;

    always_comb begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        add     = dbl_red + {1'b0, x_reg};
        if (!y_reg[Width-1]) begin
            add = dbl_red;
        end
        add_red = (add >= {1'b0, m_reg}) ? add - {1'b0, m_reg} : add;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(Width);
                x_reg    <= op_x;
                y_reg    <= op_y;
                m_reg    <= modulus;
                acc_reg  <= '0;
            end else if (busy_reg) begin
                acc_reg <= add_red[Width-1:0];
                y_reg   <= {y_reg[Width-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> sv/mrpt_seq.sv
// Test sequencer: screens, splits n-1, walks the bases and drives the multiplier.
module mrpt_seq #(
    parameter int unsigned Width = mrpt_pkg::CandWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  logic [Width-1:0] cand,
    input  logic             out_free,
    output logic             idle,
    output logic             fin,
    output logic             verdict,
    output logic             mul_start,
    output logic [Width-1:0] mul_x,
    output logic [Width-1:0] mul_y,
    output logic [Width-1:0] mul_m,
    input  logic             mul_done,
    input  logic [Width-1:0] mul_p
);

    localparam int unsigned SW = $clog2(Width + 1);
    localparam int unsigned BW = mrpt_pkg::BaseIdxW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCREEN, ST_SPLIT, ST_BASE, ST_BRED, ST_PMUL, ST_PSQR,
        ST_PNEXT, ST_CHECK, ST_SQR, ST_SQW, ST_FIN
    } state_t;

    state_t            state_reg;
    logic [Width-1:0]  n_reg, d_reg, e_reg, a_reg, x_reg, r_reg;
    logic [SW-1:0]     s_reg, k_reg;
    logic [BW-1:0]     b_reg;
    logic              verdict_reg, start_reg;
    logic [Width-1:0]  x_op_reg, y_op_reg;
    logic [1:0]        m3_reg;
    logic [Width-1:0]  sh_reg;
    logic [SW-1:0]     scnt_reg;
    logic [Width-1:0]  nm1;

    // Serial mod 3 of n: one bit per cycle, MSB first. Parity is read from bit 0.
    logic [1:0] m3_next;
    always_comb begin
        case ({m3_reg, sh_reg[Width-1]})
            3'b000: m3_next = 2'd0;
            3'b001: m3_next = 2'd1;
            3'b010: m3_next = 2'd2;
            3'b011: m3_next = 2'd0;
            3'b100: m3_next = 2'd1;
            3'b101: m3_next = 2'd2;
            default: m3_next = 2'd0;
        endcase
    end

    assign nm1 = n_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            verdict_reg <= 1'b0;
            start_reg   <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (go) begin
                        n_reg     <= cand;
                        sh_reg    <= cand;
                        m3_reg    <= '0;
                        scnt_reg  <= SW'(Width);
                        state_reg <= ST_SCREEN;
                    end
                end
                ST_SCREEN: begin
                    m3_reg   <= m3_next;
                    sh_reg   <= {sh_reg[Width-2:0], 1'b0};
                    scnt_reg <= scnt_reg - 1'b1;
                    if (scnt_reg == SW'(1)) begin
                        // answered here: below 5, or not coprime to 6 (even or divisible by 3)
                        if (n_reg < Width'(5) || !n_reg[0] || m3_next == 2'd0) begin
                            verdict_reg <= (n_reg == Width'(2)) || (n_reg == Width'(3));
                            state_reg   <= ST_FIN;
                        end else begin
                            d_reg     <= nm1;
                            s_reg     <= '0;
                            b_reg     <= '0;
                            state_reg <= ST_SPLIT;
                        end
                    end
                end
                ST_SPLIT: begin
                    if (!d_reg[0]) begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    if (b_reg == BW'(mrpt_pkg::BaseCount)) begin
                        verdict_reg <= 1'b1;
                        state_reg   <= ST_FIN;
                    end else begin
                        // base mod n: one times base, base bits walked serially
                        x_op_reg  <= Width'(1);
                        y_op_reg  <= mrpt_pkg::base_value(b_reg);
                        a_reg     <= mrpt_pkg::base_value(b_reg);
                        start_reg <= 1'b1;
                        state_reg <= ST_BRED;
                    end
                end
                ST_BRED: begin
                    if (mul_done) begin
                        if (mul_p == '0) begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= ST_BASE;
                        end else begin
                            a_reg     <= mul_p;
                            e_reg     <= d_reg;
                            r_reg     <= Width'(1);
                            state_reg <= ST_PNEXT;
                        end
                    end
                end
                ST_PNEXT: begin
                    if (e_reg == '0) begin
                        x_reg     <= r_reg;
                        state_reg <= ST_CHECK;
                    end else if (e_reg[0]) begin
                        x_op_reg  <= r_reg;
                        y_op_reg  <= a_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_PMUL;
                    end else begin
                        x_op_reg  <= a_reg;
                        y_op_reg  <= a_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_PSQR;
                    end
                end
                ST_PMUL: begin
                    if (mul_done) begin
                        r_reg     <= mul_p;
                        x_op_reg  <= a_reg;
                        y_op_reg  <= a_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_PSQR;
                    end
                end
                ST_PSQR: begin
                    if (mul_done) begin
                        a_reg     <= mul_p;
                        e_reg     <= e_reg >> 1;
                        state_reg <= ST_PNEXT;
                    end
                end
                ST_CHECK: begin
                    if (x_reg == Width'(1) || x_reg == nm1) begin
                        b_reg     <= b_reg + 1'b1;
                        state_reg <= ST_BASE;
                    end else begin
                        k_reg     <= SW'(1);
                        state_reg <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (k_reg >= s_reg) begin
                        verdict_reg <= 1'b0;
                        state_reg   <= ST_FIN;
                    end else begin
                        x_op_reg  <= x_reg;
                        y_op_reg  <= x_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_SQW;
                    end
                end
                ST_SQW: begin
                    if (mul_done) begin
                        x_reg <= mul_p;
                        k_reg <= k_reg + 1'b1;
                        if (mul_p == nm1) begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= ST_BASE;
                        end else if (mul_p == Width'(1)) begin
                            verdict_reg <= 1'b0;
                            state_reg   <= ST_FIN;
                        end else begin
                            state_reg <= ST_SQR;
                        end
                    end
                end
                ST_FIN: begin
                    // hold the verdict until the output register takes it
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign fin       = (state_reg == ST_FIN);
    assign verdict   = verdict_reg;
    assign mul_start = start_reg;
    assign mul_x     = x_op_reg;
    assign mul_y     = y_op_reg;
    assign mul_m     = n_reg;

endmodule

>>> sv/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test for 63-bit candidates.
//
// Input channel: s_valid/s_ready carry one candidate word. Output channel:
// m_valid/m_ready carry one is_prime word per candidate, in order.
// One candidate is worked at a time. A serial screen (mod 3 and
// parity) answers values below 5 and values sharing a factor with 6; such a
// word passes from the final state into the output register. The rest run
// up to seven bases; each base costs one reduction plus at most 124 modular
// products (up to two per bit of d, then up to s-1 squarings), and every
// product runs on the one bit-serial modular multiplier, which sets the rate.
// The result sits in an output register, so a new candidate is accepted
// as soon as the sequencer is idle, even while m_valid waits on m_ready;
// if that register is still full when the next result is ready, the
// sequencer holds in its final state (s_ready low) until the word is taken.
// Reset (aresetn low, synchronous) drops m_valid and returns to idle.
module miller_rabin_prime_test #(
    parameter int unsigned Width = mrpt_pkg::CandWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [Width-1:0] s_candidate,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_is_prime
);

    logic             seq_idle, seq_fin, seq_verdict;
    logic             go;
    mrpt_pkg::mul_ctrl_t mctl;
    logic [Width-1:0] mx, my, mm, mp;
    logic             out_valid_reg, out_bit_reg;
    logic             seq_rst_n;
    logic             out_free;

    assign s_ready  = seq_idle;
    assign go       = s_valid && seq_idle;
    // register empty, or its word leaves this cycle
    assign out_free = !out_valid_reg || m_ready;

    mrpt_seq #(.Width(Width)) u_seq (
        .aclk      (aclk),
        .aresetn   (seq_rst_n),
        .go        (go),
        .cand      (s_candidate),
        .out_free  (out_free),
        .idle      (seq_idle),
        .fin       (seq_fin),
        .verdict   (seq_verdict),
        .mul_start (mctl.start),
        .mul_x     (mx),
        .mul_y     (my),
        .mul_m     (mm),
        .mul_done  (mctl.done),
        .mul_p     (mp)
    );

    assign seq_rst_n  = aresetn;

    mrpt_modmul #(.Width(Width)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mctl.start),
        .op_x    (mx),
        .op_y    (my),
        .modulus (mm),
        .done    (mctl.done),
        .product (mp)
    );

    // Output register. The sequencer stays in its final state until this
    // register is free, and the verdict is loaded on the cycle it leaves,
    // so a stalled word is held and never overwritten.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_bit_reg   <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (seq_fin && out_free) begin
                out_valid_reg <= 1'b1;
                out_bit_reg   <= seq_verdict;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_is_prime = out_bit_reg;

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CandWidth   = mrpt_pkg::CandWidth;
    localparam int unsigned SanityLimit = 60_000_000;
    localparam int unsigned RandWords   = 80;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CandWidth-1:0] s_candidate = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_is_prime;

    // Stimulus words waiting for the driver, and verdicts waiting for the DUT.
    logic [CandWidth-1:0] cand_q[$];
    logic                 verdict_q[$];

    int unsigned cycle_cnt = 0;
    int unsigned fail_cnt = 0;
    bit          stim_done = 1'b0;
    bit          quiet_tail = 1'b0;
    bit          long_hold = 1'b0;

    miller_rabin_prime_test uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_candidate(s_candidate),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime)
    );

    always #5 aclk = ~aclk;

    // (x*y) mod m, exact via a 126-bit product.
    function automatic logic [CandWidth-1:0] mulmod(input logic [CandWidth-1:0] x,
                                                    input logic [CandWidth-1:0] y,
                                                    input logic [CandWidth-1:0] m);
        logic [127:0] p;
        begin
            p = {65'd0, x} * {65'd0, y};
            return CandWidth'(p % {65'd0, m});
        end
    endfunction

    function automatic logic [CandWidth-1:0] powmod(input logic [CandWidth-1:0] b,
                                                    input logic [CandWidth-1:0] e,
                                                    input logic [CandWidth-1:0] m);
        logic [CandWidth-1:0] r;
        begin
            r = 1;
            while (e != 0) begin
                if (e[0]) r = mulmod(r, b, m);
                b = mulmod(b, b, m);
                e = e >> 1;
            end
            return r;
        end
    endfunction

    // Witness set, kept local so the predictor does not lean on the package.
    function automatic logic [CandWidth-1:0] witness(input int k);
        logic [CandWidth-1:0] w[7];
        begin
            w = '{63'd2, 63'd325, 63'd9375, 63'd28178, 63'd450775, 63'd9780504,
                  63'd1795265022};
            return w[k];
        end
    endfunction

    function automatic logic primality(input logic [CandWidth-1:0] n);
        logic [CandWidth-1:0] d, a, x;
        int unsigned          s;
        bit                   hit;
        begin
            // Screen: below 2, or sharing a factor with 6.
            if (n < 2 || (n % 6) % 4 != 1) return (n | 1) == 3;
            d = n - 1;
            s = 0;
            while (!d[0]) begin
                d = d >> 1;
                s++;
            end
            for (int k = 0; k < 7; k++) begin
                a = witness(k) % n;
                if (a == 0) continue;      // base divisible by n counts as a pass
                x = powmod(a, d, n);
                if (x == 1 || x == n - 1) continue;
                hit = 1'b0;
                for (int unsigned r = 1; r < s; r++) begin
                    x = mulmod(x, x, n);
                    if (x == n - 1) begin
                        hit = 1'b1;
                        break;
                    end
                    if (x == 1) break;
                end
                if (!hit) return 1'b0;
            end
            return 1'b1;
        end
    endfunction

    function automatic logic [CandWidth-1:0] rand_word();
        return CandWidth'({$urandom(), $urandom()});
    endfunction

    // Random word of a random bit length, so small and large sizes both show up.
    function automatic logic [CandWidth-1:0] rand_sized();
        int unsigned bits;
        begin
            bits = $urandom_range(1, CandWidth);
            return rand_word() >> (CandWidth - bits);
        end
    endfunction

    initial begin
        logic [CandWidth-1:0] v;
        // Directed: tiny values, screened values, bases, extremes.
        for (int i = 0; i <= 9; i++) cand_q.push_back(CandWidth'(i));
        cand_q.push_back(63'd25);
        cand_q.push_back(63'd325);             // equals a base: skipped
        cand_q.push_back(63'd13);              // divides 325
        cand_q.push_back(63'd4294967291);      // 32-bit prime
        cand_q.push_back(63'd3215031751);      // strong pseudoprime to 2,3,5,7
        cand_q.push_back(63'd9223372036854775783);  // largest 63-bit prime
        cand_q.push_back({CandWidth{1'b1}});
        cand_q.push_back({1'b1, {(CandWidth-1){1'b0}}});
        cand_q.push_back({1'b1, {(CandWidth-2){1'b0}}, 1'b1});
        cand_q.push_back(63'h2AAA_AAAA_AAAA_AAAB);
        cand_q.push_back(63'h5555_5555_5555_5555);
        cand_q.push_back(63'd1000000007 * 63'd998244353);  // semiprime
        for (int i = 0; i < RandWords; i++) begin
            case ($urandom_range(0, 3))
                0: v = rand_word();
                1: v = rand_sized();
                2: begin
                    // Push toward the full test: make the value 1 or 5 mod 6.
                    v = rand_sized();
                    v = v - (v % 6) + (($urandom_range(0, 1) != 0) ? 1 : 5);
                end
                default: v = CandWidth'($urandom_range(0, 200));
            endcase
            cand_q.push_back(v);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver.
    int unsigned src_gap = 0;
    int unsigned sent = 0;
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                verdict_q.push_back(primality(s_candidate));
                sent = sent + 1;
            end
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap = src_gap - 1;
                    s_valid <= 1'b0;
                end else if (cand_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_candidate <= cand_q.pop_front();
                    if (!quiet_tail && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 11);
                end else begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
            quiet_tail <= (cand_q.size() < 15);
        end
    end

    // Sink with random stalls, plus one long hold-off around word 20
    // so the output register fills and s_ready drops.
    int unsigned sink_gap = 0;
    int unsigned hold_cnt = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!long_hold && sent == 20) begin
                long_hold <= 1'b1;
                hold_cnt = 300_000;
            end
            if (hold_cnt != 0) begin
                hold_cnt = hold_cnt - 1;
                m_ready <= 1'b0;
            end else if (sink_gap != 0) begin
                sink_gap = sink_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 4) == 0)
                    sink_gap = $urandom_range(1, 11);
            end
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        logic want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected word: is_prime=%0b", m_is_prime);
                fail_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (m_is_prime !== want) begin
                    $error("is_prime: expected %0b, actual %0b", want, m_is_prime);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        wait (stim_done && verdict_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (fail_cnt == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (cycle_cnt == SanityLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

>>> filelist.f
sv/mrpt_pkg.sv
sv/mrpt_modmul.sv
sv/mrpt_seq.sv
sv/miller_rabin_prime_test.sv
verif/tb.sv
